// ----- rtl/vpf_pkg.sv -----
// Shared types, command codes and arithmetic helpers for the vector path flattener.
package vpf_pkg;

   localparam int SUBPATH_POINTS_DEF = 64;
   localparam int CURVE_STEPS_DEF    = 12;
   localparam int COORD_W            = 32;
   localparam int OP_W               = 4;
   localparam int MIN_EMIT_POINTS    = 3;

   typedef enum logic [OP_W-1:0] {
      OP_MOVE         = 4'd0,
      OP_LINE         = 4'd1,
      OP_HORIZ        = 4'd2,
      OP_VERT         = 4'd3,
      OP_CUBIC        = 4'd4,
      OP_QUAD         = 4'd5,
      OP_SMOOTH_CUBIC = 4'd6,
      OP_SMOOTH_QUAD  = 4'd7,
      OP_ARC          = 4'd8,
      OP_CLOSE        = 4'd9,
      OP_END          = 4'd10,
      OP_UNKNOWN      = 4'd11
   } op_type;

   // Saturating signed add of two coordinates.
   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      if (s[COORD_W] != s[COORD_W-1]) begin
         sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         sat_add = s[COORD_W-1:0];
      end
   endfunction

   // Integer Bernstein weight of control point j at step i of n.
   function automatic int bern_weight(input int n, input int i, input int j, input logic cubic);
      int a;
      int b;
      int w;
      a = n - i;
      b = i;
      w = 0;
      if (cubic) begin
         unique case (j)
            0:       w = a * a * a;
            1:       w = 3 * a * a * b;
            2:       w = 3 * a * b * b;
            default: w = b * b * b;
         endcase
      end else begin
         unique case (j)
            0:       w = a * a;
            1:       w = 2 * a * b;
            2:       w = b * b;
            default: w = 0;
         endcase
      end
      return w;
   endfunction

endpackage

// ----- rtl/vpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vpf_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vector_path_flattener_core.sv -----
// Path flattener: one command per item, subpath vertices buffered in RAM, emitted on flush.
// A line-type command is decoded, then appended; a curve builds each vertex axis by
//   axis from weight, multiply and accumulate over K = 4 (cubic) or 3 (quadratic) points,
//   then a radix-16 divide (DIG_N = 8 quotient digits); a flush waits on output stalls.
// Throughput: one command at a time; req_tready is high only while idle.
// Reset: synchronous, active high; clears points, counters and flags, no RAM clear pass.
module vector_path_flattener_core #(
   parameter int SubpathPoints = vpf_pkg::SUBPATH_POINTS_DEF,
   parameter int CurveSteps    = vpf_pkg::CURVE_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x[31:0], a_y[63:32], b_x[95:64], b_y[127:96], c_x[159:128], c_y[191:160]
   input  logic [191:0] req_tdata,
   // op[3:0], relative[4]
   input  logic [4:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x[31:0], point_y[63:32]
   output logic [63:0]  rsp_tdata,
   // last_point
   output logic         rsp_tlast,
   // truncated
   output logic         rsp_tuser
);

   localparam int CW       = vpf_pkg::COORD_W;
   localparam int ADDR_W   = $clog2(SubpathPoints);
   localparam int CNT_W    = $clog2(SubpathPoints + 1);
   localparam int IDX_W    = $clog2(CurveSteps + 1);
   localparam int DIV_CUB  = CurveSteps * CurveSteps * CurveSteps;
   localparam int DIV_QUAD = CurveSteps * CurveSteps;
   localparam int DEN_W    = $clog2(DIV_CUB + 1);
   localparam int WGT_W    = DEN_W + 1;
   localparam int PRD_W    = CW + WGT_W;
   localparam int ACC_W    = 50;
   localparam int DIG_W    = 4;
   localparam int DIG_N    = CW / DIG_W;
   localparam int TRL_W    = DEN_W + DIG_W;
   localparam int DCNT_W   = $clog2(DIG_N + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_APP, S_FL_RD, S_FL_LD, S_FL_END,
      S_W, S_MUL, S_ACC, S_DPREP, S_DIV
   } state_type;

   // What to do once the current append or flush is done.
   typedef enum logic [2:0] {
      POST_NONE, POST_CURVE, POST_MOVE, POST_CLOSE, POST_END, POST_STOP
   } post_type;

   state_type state_ff;
   post_type  post_ff;

   // Latched command
   vpf_pkg::op_type        op_ff;
   logic                   rel_ff;
   logic signed [CW-1:0]   ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;

   // Path state
   logic signed [CW-1:0]   cur_x_ff, cur_y_ff, start_x_ff, start_y_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   open_ff, stopped_ff, ovf_ff;

   // Point to append
   logic signed [CW-1:0]   app_x_ff, app_y_ff;

   // Curve evaluation
   logic signed [CW-1:0]   p_x_ff [4];
   logic signed [CW-1:0]   p_y_ff [4];
   logic                   cubic_ff, axis_ff;
   logic [IDX_W-1:0]       i_ff;
   logic [1:0]             j_ff;
   logic signed [WGT_W-1:0] w_ff;
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [DEN_W-1:0]       rem_ff;
   logic [CW-1:0]          quo_ff;
   logic                   neg_ff;
   logic [DCNT_W-1:0]      dcnt_ff;

   // Flush
   logic [ADDR_W-1:0]      rd_idx_ff;

   // Output register
   logic                   rsp_valid_ff, rsp_last_ff, rsp_trunc_ff;
   logic [2*CW-1:0]        rsp_data_ff;

   // RAM ports
   logic                   wr_en, rd_en;
   logic [2*CW-1:0]        rd_data;

   // Relative-resolved coordinates
   logic signed [CW-1:0]   ra_x_in, ra_y_in, rb_x_in, rb_y_in, rc_x_in, rc_y_in;

   logic                   acc_fire, rsp_free, flush_emit, rd_last, cnt_full;
   logic [1:0]             j_last;
   logic signed [ACC_W-1:0] acc_in, round_in;
   logic [ACC_W-1:0]       mag_in;
   logic [TRL_W-1:0]       trial, dig_sub;
   logic [DIG_W-1:0]       dig_val;
   logic [CW-1:0]          quot_val;
   logic signed [CW-1:0]   div_res;
   logic signed [WGT_W-1:0] w_in;

   assign acc_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign flush_emit = open_ff && (count_ff >= CNT_W'(vpf_pkg::MIN_EMIT_POINTS));
   assign rd_last    = (CNT_W'(rd_idx_ff) == (count_ff - CNT_W'(1)));
   assign cnt_full   = (count_ff >= CNT_W'(SubpathPoints));
   assign j_last     = cubic_ff ? 2'd3 : 2'd2;

   assign ra_x_in = rel_ff ? vpf_pkg::sat_add(ax_ff, cur_x_ff) : ax_ff;
   assign ra_y_in = rel_ff ? vpf_pkg::sat_add(ay_ff, cur_y_ff) : ay_ff;
   assign rb_x_in = rel_ff ? vpf_pkg::sat_add(bx_ff, cur_x_ff) : bx_ff;
   assign rb_y_in = rel_ff ? vpf_pkg::sat_add(by_ff, cur_y_ff) : by_ff;
   assign rc_x_in = rel_ff ? vpf_pkg::sat_add(cx_ff, cur_x_ff) : cx_ff;
   assign rc_y_in = rel_ff ? vpf_pkg::sat_add(cy_ff, cur_y_ff) : cy_ff;

   assign w_in = WGT_W'(vpf_pkg::bern_weight(CurveSteps, int'(i_ff), int'(j_ff), cubic_ff));

   // Accumulate the weighted term; the first term starts a fresh sum.
   assign acc_in = ((j_ff == 2'd0) ? ACC_W'(0) : acc_ff)
                   + {{(ACC_W-PRD_W){prod_ff[PRD_W-1]}}, prod_ff};

   // Add half the divisor for round-to-nearest, ties up.
   assign round_in = acc_ff + ACC_W'(den_ff >> 1);

   // Magnitude to divide; a negative sum gets d-1 added so the result is a floor.
   assign mag_in = round_in[ACC_W-1]
                   ? (ACC_W'(0) - ACC_W'(round_in)) + ACC_W'(den_ff) - ACC_W'(1)
                   : ACC_W'(round_in);

   // One radix-16 long-division step: remainder and the next dividend nibble.
   assign trial = {rem_ff, quo_ff[CW-1 -: DIG_W]};

   // Pick the largest multiple of the divisor that fits.
   always_comb begin
      dig_val = '0;
      dig_sub = '0;
      for (int k = 1; k < (1 << DIG_W); k++) begin
         if (trial >= (cubic_ff ? TRL_W'(k * DIV_CUB) : TRL_W'(k * DIV_QUAD))) begin
            dig_val = DIG_W'(k);
            dig_sub = cubic_ff ? TRL_W'(k * DIV_CUB) : TRL_W'(k * DIV_QUAD);
         end
      end
   end

   // Floor quotient: negate the magnitude quotient for negative sums.
   assign quot_val = neg_ff ? (CW'(0) - quo_ff) : quo_ff;
   assign div_res  = quot_val;

   assign wr_en = (state_ff == S_APP) && open_ff && !cnt_full;
   assign rd_en = (state_ff == S_FL_RD) && flush_emit && rsp_free;

   vpf_ram #(
      .Width (2 * CW),
      .Depth (SubpathPoints)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({app_y_ff, app_x_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         post_ff      <= POST_NONE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         stopped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken; a load below overrides.
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (acc_fire) begin
                  op_ff    <= vpf_pkg::op_type'(req_tuser[3:0]);
                  rel_ff   <= req_tuser[4];
                  ax_ff    <= req_tdata[31:0];
                  ay_ff    <= req_tdata[63:32];
                  bx_ff    <= req_tdata[95:64];
                  by_ff    <= req_tdata[127:96];
                  cx_ff    <= req_tdata[159:128];
                  cy_ff    <= req_tdata[191:160];
                  state_ff <= S_DEC;
               end
            end

            S_DEC: begin
               rd_idx_ff <= '0;
               i_ff      <= IDX_W'(1);
               j_ff      <= 2'd0;
               axis_ff   <= 1'b0;
               p_x_ff[0] <= cur_x_ff;
               p_y_ff[0] <= cur_y_ff;
               if (stopped_ff && (op_ff != vpf_pkg::OP_END)) begin
                  state_ff <= S_IDLE;
               end else begin
                  unique case (op_ff)
                     vpf_pkg::OP_MOVE: begin
                        cur_x_ff <= ra_x_in;
                        cur_y_ff <= ra_y_in;
                        post_ff  <= POST_MOVE;
                        state_ff <= S_FL_RD;
                     end
                     vpf_pkg::OP_LINE, vpf_pkg::OP_ARC: begin
                        cur_x_ff <= ra_x_in;
                        cur_y_ff <= ra_y_in;
                        app_x_ff <= ra_x_in;
                        app_y_ff <= ra_y_in;
                        post_ff  <= POST_NONE;
                        state_ff <= S_APP;
                     end
                     vpf_pkg::OP_HORIZ: begin
                        cur_x_ff <= ra_x_in;
                        app_x_ff <= ra_x_in;
                        app_y_ff <= cur_y_ff;
                        post_ff  <= POST_NONE;
                        state_ff <= S_APP;
                     end
                     vpf_pkg::OP_VERT: begin
                        cur_y_ff <= ra_y_in;
                        app_x_ff <= cur_x_ff;
                        app_y_ff <= ra_y_in;
                        post_ff  <= POST_NONE;
                        state_ff <= S_APP;
                     end
                     vpf_pkg::OP_CUBIC: begin
                        p_x_ff[1] <= ra_x_in;
                        p_y_ff[1] <= ra_y_in;
                        p_x_ff[2] <= rb_x_in;
                        p_y_ff[2] <= rb_y_in;
                        p_x_ff[3] <= rc_x_in;
                        p_y_ff[3] <= rc_y_in;
                        cur_x_ff  <= rc_x_in;
                        cur_y_ff  <= rc_y_in;
                        cubic_ff  <= 1'b1;
                        den_ff    <= DEN_W'(DIV_CUB);
                        state_ff  <= S_W;
                     end
                     vpf_pkg::OP_SMOOTH_CUBIC: begin
                        p_x_ff[1] <= cur_x_ff;
                        p_y_ff[1] <= cur_y_ff;
                        p_x_ff[2] <= ra_x_in;
                        p_y_ff[2] <= ra_y_in;
                        p_x_ff[3] <= rb_x_in;
                        p_y_ff[3] <= rb_y_in;
                        cur_x_ff  <= rb_x_in;
                        cur_y_ff  <= rb_y_in;
                        cubic_ff  <= 1'b1;
                        den_ff    <= DEN_W'(DIV_CUB);
                        state_ff  <= S_W;
                     end
                     vpf_pkg::OP_QUAD: begin
                        p_x_ff[1] <= ra_x_in;
                        p_y_ff[1] <= ra_y_in;
                        p_x_ff[2] <= rb_x_in;
                        p_y_ff[2] <= rb_y_in;
                        p_x_ff[3] <= rb_x_in;
                        p_y_ff[3] <= rb_y_in;
                        cur_x_ff  <= rb_x_in;
                        cur_y_ff  <= rb_y_in;
                        cubic_ff  <= 1'b0;
                        den_ff    <= DEN_W'(DIV_QUAD);
                        state_ff  <= S_W;
                     end
                     vpf_pkg::OP_SMOOTH_QUAD: begin
                        p_x_ff[1] <= cur_x_ff;
                        p_y_ff[1] <= cur_y_ff;
                        p_x_ff[2] <= ra_x_in;
                        p_y_ff[2] <= ra_y_in;
                        p_x_ff[3] <= ra_x_in;
                        p_y_ff[3] <= ra_y_in;
                        cur_x_ff  <= ra_x_in;
                        cur_y_ff  <= ra_y_in;
                        cubic_ff  <= 1'b0;
                        den_ff    <= DEN_W'(DIV_QUAD);
                        state_ff  <= S_W;
                     end
                     vpf_pkg::OP_CLOSE: begin
                        app_x_ff <= start_x_ff;
                        app_y_ff <= start_y_ff;
                        post_ff  <= POST_CLOSE;
                        state_ff <= S_APP;
                     end
                     vpf_pkg::OP_END: begin
                        post_ff  <= POST_END;
                        state_ff <= S_FL_RD;
                     end
                     default: begin
                        // Unknown command: flush, then ignore until end of path.
                        post_ff  <= POST_STOP;
                        state_ff <= S_FL_RD;
                     end
                  endcase
               end
            end

            S_APP: begin
               // The RAM write happens here; only the counters and the overflow flag move.
               if (open_ff) begin
                  if (cnt_full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end
               unique case (post_ff)
                  POST_CLOSE: begin
                     rd_idx_ff <= '0;
                     state_ff  <= S_FL_RD;
                  end
                  POST_CURVE: begin
                     if (i_ff == IDX_W'(CurveSteps)) begin
                        state_ff <= S_IDLE;
                     end else begin
                        i_ff     <= i_ff + IDX_W'(1);
                        j_ff     <= 2'd0;
                        axis_ff  <= 1'b0;
                        state_ff <= S_W;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end

            S_W: begin
               w_ff     <= w_in;
               state_ff <= S_MUL;
            end

            S_MUL: begin
               prod_ff  <= w_ff * (axis_ff ? p_y_ff[j_ff] : p_x_ff[j_ff]);
               state_ff <= S_ACC;
            end

            S_ACC: begin
               acc_ff <= acc_in;
               if (j_ff == j_last) begin
                  state_ff <= S_DPREP;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= S_W;
               end
            end

            S_DPREP: begin
               // Split the magnitude: the top part is already below the divisor.
               neg_ff   <= round_in[ACC_W-1];
               rem_ff   <= mag_in[CW +: DEN_W];
               quo_ff   <= mag_in[CW-1:0];
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end

            S_DIV: begin
               if (dcnt_ff == DCNT_W'(DIG_N)) begin
                  j_ff <= 2'd0;
                  if (!axis_ff) begin
                     app_x_ff <= div_res;
                     axis_ff  <= 1'b1;
                     state_ff <= S_W;
                  end else begin
                     app_y_ff <= div_res;
                     axis_ff  <= 1'b0;
                     post_ff  <= POST_CURVE;
                     state_ff <= S_APP;
                  end
               end else begin
                  // Shift out one dividend nibble, shift in one quotient digit.
                  dcnt_ff <= dcnt_ff + DCNT_W'(1);
                  rem_ff  <= DEN_W'(trial - dig_sub);
                  quo_ff  <= {quo_ff[CW-DIG_W-1:0], dig_val};
               end
            end

            S_FL_RD: begin
               if (!flush_emit) begin
                  state_ff <= S_FL_END;
               end else if (rsp_free) begin
                  state_ff <= S_FL_LD;
               end
            end

            S_FL_LD: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= rd_data;
               rsp_last_ff  <= rd_last;
               rsp_trunc_ff <= ovf_ff;
               if (rd_last) begin
                  state_ff <= S_FL_END;
               end else begin
                  rd_idx_ff <= rd_idx_ff + ADDR_W'(1);
                  state_ff  <= S_FL_RD;
               end
            end

            S_FL_END: begin
               count_ff <= '0;
               open_ff  <= 1'b0;
               ovf_ff   <= 1'b0;
               unique case (post_ff)
                  POST_MOVE: begin
                     // Start a new subpath at the move point.
                     open_ff    <= 1'b1;
                     app_x_ff   <= cur_x_ff;
                     app_y_ff   <= cur_y_ff;
                     start_x_ff <= cur_x_ff;
                     start_y_ff <= cur_y_ff;
                     post_ff    <= POST_NONE;
                     state_ff   <= S_APP;
                  end
                  POST_CLOSE: begin
                     cur_x_ff <= start_x_ff;
                     cur_y_ff <= start_y_ff;
                     state_ff <= S_IDLE;
                  end
                  POST_END: begin
                     stopped_ff <= 1'b0;
                     cur_x_ff   <= '0;
                     cur_y_ff   <= '0;
                     start_x_ff <= '0;
                     start_y_ff <= '0;
                     state_ff   <= S_IDLE;
                  end
                  POST_STOP: begin
                     stopped_ff <= 1'b1;
                     state_ff   <= S_IDLE;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_trunc_ff;

endmodule

// ----- rtl/vpf_checker.sv -----
// Port-level checker for the path flattener, bound to the top level.
module vpf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed or dropped");

   // Busy right after taking an item.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again right after accepting an item");

   // A new result only appears while a command is being worked.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("result item started while idle");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

endmodule

bind vector_path_flattener_core vpf_checker u_vpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
